/* design/uhx_pkg.sv */
// ----------------------------------------------------------------------------
// uhx_pkg
// Shared types, character codes and helpers for the URL host name extractor.
// ----------------------------------------------------------------------------
package uhx_pkg;

    // Default host name buffer depth
    localparam int HOST_MAX_DEF = 64;

    // Character codes
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    // Input beat
    typedef struct packed {
        logic [7:0] url_byte;
        logic       last_of_url;
    } url_beat_t;

    // Output beat
    typedef struct packed {
        logic [7:0] host_byte;
        logic       byte_valid;
        logic       run_end;
        logic [1:0] status;
    } host_beat_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_PROTO,
        PH_COLON,
        PH_SLASH,
        PH_HOST,
        PH_DONE
    } phase_t;

    // Kind of result run handed from parser to emitter
    typedef enum logic [1:0] {
        JOB_NAME,
        JOB_EMPTY,
        JOB_BAD,
        JOB_LONG
    } job_kind_t;

    typedef struct packed {
        logic      valid;
        job_kind_t kind;
    } job_t;

    // Letters, digits and underscore
    function automatic logic is_proto_char(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
               (c == CH_UNDERSCORE);
    endfunction

    // Protocol characters plus dot and hyphen
    function automatic logic is_host_char(input logic [7:0] c);
        return is_proto_char(c) || (c == CH_DOT) || (c == CH_DASH);
    endfunction

endpackage

/* design/uhx_parser.sv */
// ----------------------------------------------------------------------------
// uhx_parser
// Per-byte phase machine: writes kept characters into the name buffer and
// hands a finished run (kind and length) to the emitter.
// ----------------------------------------------------------------------------
module uhx_parser
    import uhx_pkg::*;
#(
    parameter int HOST_MAX = HOST_MAX_DEF,
    parameter int ADDR_W   = (HOST_MAX > 1) ? $clog2(HOST_MAX) : 1,
    parameter int LEN_W    = $clog2(HOST_MAX + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  url_beat_t         beat,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output job_t              job,
    output logic [LEN_W-1:0]  job_len
);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next, len_k;
    logic             ov_reg, ov_next, ov_k;
    logic             keep, clr, fin, err, full;
    logic [7:0]       c;
    logic             last;

    assign c    = beat.url_byte;
    assign last = beat.last_of_url;

    // Next phase and per-byte actions
    always_comb
    begin
        phase_next = phase_reg;
        keep       = 1'b0;
        clr        = 1'b0;
        fin        = 1'b0;
        err        = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_PROTO:
                begin
                    if (is_proto_char(c))
                        keep = 1'b1;
                    else if (c == CH_DOT || c == CH_DASH)
                    begin
                        keep       = 1'b1;
                        phase_next = PH_HOST;
                    end
                    else if (c == CH_COLON)
                        phase_next = PH_COLON;
                    else if (c == CH_SLASH)
                        fin = 1'b1;
                    else
                    begin
                        fin = 1'b1;
                        err = 1'b1;
                    end
                end
                PH_COLON:
                begin
                    if (c == CH_SLASH)
                        phase_next = PH_SLASH;
                    else
                        fin = 1'b1;
                end
                PH_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        clr        = 1'b1;
                        phase_next = PH_HOST;
                    end
                    else
                        fin = 1'b1;
                end
                PH_HOST:
                begin
                    if (is_host_char(c))
                        keep = 1'b1;
                    else if (c == CH_COLON || c == CH_SLASH)
                        fin = 1'b1;
                    else
                    begin
                        fin = 1'b1;
                        err = 1'b1;
                    end
                end
                default:
                begin
                    // done: skip bytes until the last flag
                    if (last)
                    begin
                        phase_next = PH_PROTO;
                        clr        = 1'b1;
                    end
                end
            endcase
            // the last byte always ends a live parse
            if (phase_reg != PH_DONE && last)
                fin = 1'b1;
            if (fin)
                phase_next = last ? PH_PROTO : PH_DONE;
        end
    end

    // Buffer write, updated length and run hand-off
    always_comb
    begin
        full    = (len_reg == LEN_W'(HOST_MAX));
        wr_en   = keep && !full;
        wr_addr = len_reg[ADDR_W-1:0];
        wr_data = c;
        if (clr)
        begin
            len_k = '0;
            ov_k  = 1'b0;
        end
        else
        begin
            len_k = wr_en ? LEN_W'(len_reg + LEN_W'(1)) : len_reg;
            ov_k  = ov_reg || (keep && full);
        end
        job.valid = fin;
        priority if (err)
            job.kind = JOB_BAD;
        else if (ov_k)
            job.kind = JOB_LONG;
        else if (len_k == '0)
            job.kind = JOB_EMPTY;
        else
            job.kind = JOB_NAME;
        job_len  = len_k;
        len_next = fin ? '0 : len_k;
        ov_next  = fin ? 1'b0 : ov_k;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PROTO;
            len_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

/* design/uhx_emitter.sv */
// ----------------------------------------------------------------------------
// uhx_emitter
// Holds the name buffer memory and plays a finished run out as beats:
// read issue, registered read data stage, then the output register.
// ----------------------------------------------------------------------------
module uhx_emitter
    import uhx_pkg::*;
#(
    parameter int HOST_MAX = HOST_MAX_DEF,
    parameter int ADDR_W   = (HOST_MAX > 1) ? $clog2(HOST_MAX) : 1,
    parameter int LEN_W    = $clog2(HOST_MAX + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  job_t              job,
    input  logic [LEN_W-1:0]  job_len,
    output logic              busy,
    output logic              host_valid,
    input  logic              host_stall,
    output host_beat_t        host_data
);

    logic [7:0]       mem [HOST_MAX];
    logic [7:0]       mem_q;

    logic             job_active_reg;
    job_kind_t        kind_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] cnt_reg;

    logic             rd_valid_reg;
    logic             rd_mem_reg;
    logic             rd_end_reg;
    logic [1:0]       rd_status_reg;

    logic             out_valid_reg;
    host_beat_t       out_reg;

    logic             move, issue, name_job, last_issue;
    logic [1:0]       job_status;

    // Stage control
    always_comb
    begin
        move       = rd_valid_reg && (!out_valid_reg || !host_stall);
        issue      = job_active_reg && (!rd_valid_reg || move);
        name_job   = (kind_reg == JOB_NAME);
        last_issue = !name_job || (cnt_reg == LEN_W'(len_reg - LEN_W'(1)));
        unique case (kind_reg)
            JOB_BAD:  job_status = ST_BAD_CHAR;
            JOB_LONG: job_status = ST_TOO_LONG;
            default:  job_status = ST_OK;
        endcase
    end

    // Name buffer: writes come only while no run is active, so no overlap
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (issue && name_job)
            mem_q <= mem[cnt_reg[ADDR_W-1:0]];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_active_reg <= 1'b0;
            cnt_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (job.valid)
            begin
                job_active_reg <= 1'b1;
                cnt_reg        <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= LEN_W'(cnt_reg + LEN_W'(1));
                if (last_issue)
                    job_active_reg <= 1'b0;
            end

            if (issue)
                rd_valid_reg <= 1'b1;
            else if (move)
                rd_valid_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !host_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (job.valid)
        begin
            kind_reg <= job.kind;
            len_reg  <= job_len;
        end
        if (issue)
        begin
            rd_mem_reg    <= name_job;
            rd_end_reg    <= last_issue;
            rd_status_reg <= job_status;
        end
        if (move)
        begin
            out_reg.host_byte  <= rd_mem_reg ? mem_q : 8'h00;
            out_reg.byte_valid <= rd_mem_reg;
            out_reg.run_end    <= rd_end_reg;
            out_reg.status     <= rd_status_reg;
        end
    end

    assign busy       = job_active_reg;
    assign host_valid = out_valid_reg;
    assign host_data  = out_reg;

    // A new run only starts once the previous one has been fully issued
    a_job_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid |-> !job_active_reg)
        else $error("run handed over while previous run still issuing");

    // No buffer write while the buffer is being read out
    a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !job_active_reg)
        else $error("name buffer written during read-out");

    // Read index stays inside the run
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (job_active_reg && name_job) |-> (cnt_reg < len_reg))
        else $error("read index past run length");

    // Status and empty beats are single-beat runs carrying no character
    a_nochar_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.byte_valid) |-> out_reg.run_end)
        else $error("non-character beat without run end");

    a_err_nochar: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK) |-> !out_reg.byte_valid)
        else $error("error beat flagged as character");

endmodule

/* design/url_hostname_extractor.sv */
// ----------------------------------------------------------------------------
// url_hostname_extractor
// Extracts the host name from a URL streamed one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel url_valid/url_stall/url_data carries one URL byte per beat
//   with last_of_url on the final byte. Output channel host_valid/host_stall/
//   host_data carries the extracted host name, one byte per beat, with
//   run_end on the last beat of each URL; an empty name, an invalid
//   character or a too-long name gives one beat with byte_valid low.
//   Parsing takes one byte per cycle while url_stall is low. When a parse
//   ends, url_stall rises and the name buffer memory is read out at one byte
//   per cycle; the first result beat passes through read issue, read data
//   and the output register. url_stall stays high until every beat of the
//   run has been issued from the single memory read port; bytes after the
//   end of a parse are taken at one per cycle and dropped once it falls.
//   When the receiver stalls, the output register and read stage hold and
//   read-out pauses. Reset returns the parser to the protocol phase and
//   empties all stages; the buffer contents need no clearing.
// ----------------------------------------------------------------------------
module url_hostname_extractor
    import uhx_pkg::*;
#(
    parameter int HOST_MAX = HOST_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       url_valid,
    output logic       url_stall,
    input  url_beat_t  url_data,
    output logic       host_valid,
    input  logic       host_stall,
    output host_beat_t host_data
);

    localparam int ADDR_W = (HOST_MAX > 1) ? $clog2(HOST_MAX) : 1;
    localparam int LEN_W  = $clog2(HOST_MAX + 1);

    logic              accept;
    logic              busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    job_t              job;
    logic [LEN_W-1:0]  job_len;

    // Input is held off while a run is being read out of the buffer
    assign url_stall = busy;
    assign accept    = url_valid && !busy;

    uhx_parser #(
        .HOST_MAX (HOST_MAX),
        .ADDR_W   (ADDR_W),
        .LEN_W    (LEN_W)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .beat    (url_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .job     (job),
        .job_len (job_len)
    );

    uhx_emitter #(
        .HOST_MAX (HOST_MAX),
        .ADDR_W   (ADDR_W),
        .LEN_W    (LEN_W)
    ) u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job        (job),
        .job_len    (job_len),
        .busy       (busy),
        .host_valid (host_valid),
        .host_stall (host_stall),
        .host_data  (host_data)
    );

endmodule
